@@ hw/rtl/vfg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vfg_pkg;

  // Operation codes carried by func_i
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_FADE   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_GRID_COLUMNS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXTENT_X     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXTENT_Y     = 3'd3;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned ExtentW  = 11;

  // Reset values of the registers
  localparam logic [SizeW-1:0]   GRID_COLUMNS_RST = 7'd64;
  localparam logic [SizeW-1:0]   GRID_ROWS_RST    = 7'd64;
  localparam logic [ExtentW-1:0] EXTENT_X_RST     = 11'd1024;
  localparam logic [ExtentW-1:0] EXTENT_Y_RST     = 11'd768;

  // Span of a position axis in Q11.4: extent * 16
  localparam int unsigned SpanW = ExtentW + 4;

  // 0.1 in Q0.16
  localparam logic signed [16:0] TENTH_Q16 = 17'sd6554;

endpackage

`default_nettype wire

@@ hw/rtl/vector_field_grid_sample_and_splat_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Grid of 2D force vectors (Q8.8 x and y per cell) held in one block RAM.
// Input channel (in_valid_i / in_stall_o) takes one item per operation:
// sample, add, fade all or clear all. Output channel (out_valid_o /
// out_stall_i) returns exactly one item per input item, in order.
// Config writes (cfg_valid_i / cfg_ready_o) set grid size and extent; cfg_ready_o
// is high only while the block is idle, and an item taken in that same cycle
// still runs with the old settings.
// One item at a time. A sample or add runs through ST_DIV, ST_ADDR, ST_READ,
// ST_CALC and ST_DONE to the output register; the serial cell-index divider
// gives QW = clog2(MAX+1) quotient bits (7 at 64 cells). A position outside the
// extent skips the divider and goes from accept straight to ST_DONE. Fade walks the
// whole RAM through a three-stage read-multiply-write pipe, then ST_DONE;
// clear writes one word per cycle, then ST_DONE. The next item can be taken
// from the cycle in which the result appears on the output.
// After reset the RAM is zeroed, one word per cycle (4096 words at the
// default size); in_stall_o stays high until that is done.
// While out_stall_i holds a result, the block still takes and works on the
// next item, and stalls its input only until the output register is free.
module vector_field_grid_sample_and_splat_core #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vfg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [vfg_pkg::CfgDataW-1:0]  cfg_data_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic signed [15:0]            pos_x_i,
  input  wire logic signed [15:0]            pos_y_i,
  input  wire logic signed [15:0]            vec_x_i,
  input  wire logic signed [15:0]            vec_y_i,
  input  wire logic [15:0]                   fade_factor_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [15:0]                 force_x_o,
  output logic signed [15:0]                 force_y_o,
  output logic                               out_of_range_o
);

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned QWC   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned QWR   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CEW   = (QWC > vfg_pkg::SizeW) ? QWC : vfg_pkg::SizeW;
  localparam int unsigned REW   = (QWR > vfg_pkg::SizeW) ? QWR : vfg_pkg::SizeW;
  localparam int unsigned SPW   = vfg_pkg::SpanW;
  localparam int unsigned NWC   = SPW + QWC;
  localparam int unsigned NWR   = SPW + QWR;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [8:0] {
    ST_INIT = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_DIV  = 9'b000000100,
    ST_ADDR = 9'b000001000,
    ST_READ = 9'b000010000,
    ST_CALC = 9'b000100000,
    ST_FADE = 9'b001000000,
    ST_CLR  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [vfg_pkg::SizeW-1:0]   grid_columns_q, grid_rows_q;
  logic [vfg_pkg::ExtentW-1:0] extent_x_q, extent_y_q;

  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= vfg_pkg::GRID_COLUMNS_RST;
      grid_rows_q    <= vfg_pkg::GRID_ROWS_RST;
      extent_x_q     <= vfg_pkg::EXTENT_X_RST;
      extent_y_q     <= vfg_pkg::EXTENT_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        vfg_pkg::CFG_GRID_COLUMNS: grid_columns_q <= cfg_data_i[vfg_pkg::SizeW-1:0];
        vfg_pkg::CFG_GRID_ROWS:    grid_rows_q    <= cfg_data_i[vfg_pkg::SizeW-1:0];
        vfg_pkg::CFG_EXTENT_X:     extent_x_q     <= cfg_data_i;
        vfg_pkg::CFG_EXTENT_Y:     extent_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes and spans
  logic [QWC-1:0] cols_eff;
  logic [QWR-1:0] rows_eff;
  logic [SPW-1:0] span_x, span_y;

  always_comb begin
    if (grid_columns_q == '0) cols_eff = QWC'(1);
    else if (CEW'(grid_columns_q) > CEW'(MAX_COLUMNS)) cols_eff = QWC'(MAX_COLUMNS);
    else cols_eff = QWC'(grid_columns_q);
    if (grid_rows_q == '0) rows_eff = QWR'(1);
    else if (REW'(grid_rows_q) > REW'(MAX_ROWS)) rows_eff = QWR'(MAX_ROWS);
    else rows_eff = QWR'(grid_rows_q);
    span_x = (extent_x_q == '0) ? SPW'(16) : {extent_x_q, 4'b0000};
    span_y = (extent_y_q == '0) ? SPW'(16) : {extent_y_q, 4'b0000};
  end

  // ---------------------------------------------------------------
  // Input accept and range check
  logic in_acc, oor_x, oor_y, oor;
  logic result_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign oor_x      = pos_x_i[15] || (pos_x_i[14:0] > span_x);
  assign oor_y      = pos_y_i[15] || (pos_y_i[14:0] > span_y);
  assign oor        = oor_x || oor_y;

  logic is_cell_op;
  assign is_cell_op = (func_i == vfg_pkg::FUNC_SAMPLE) || (func_i == vfg_pkg::FUNC_ADD);

  // Cell index dividers: floor(pos * cells / span)
  logic           div_start;
  logic           busy_x, busy_y;
  logic [QWC-1:0] quot_x;
  logic [QWR-1:0] quot_y;
  logic [NWC-1:0] dvd_x;
  logic [NWR-1:0] dvd_y;

  assign div_start = in_acc && is_cell_op && !oor;
  assign dvd_x     = NWC'(pos_x_i[14:0]) * NWC'(cols_eff);
  assign dvd_y     = NWR'(pos_y_i[14:0]) * NWR'(rows_eff);

  vfg_div #(.NW(NWC), .DW(SPW), .QW(QWC)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (span_x),
    .busy_o     (busy_x),
    .quot_o     (quot_x)
  );

  vfg_div #(.NW(NWR), .DW(SPW), .QW(QWR)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (span_y),
    .busy_o     (busy_y),
    .quot_o     (quot_y)
  );

  // ---------------------------------------------------------------
  // Item registers
  logic                    is_add_q;
  logic signed [15:0]      vec_x_q, vec_y_q;
  logic [15:0]             fade_q;
  logic [QWC-1:0]          cols_q, col_q;
  logic [QWR-1:0]          rows_q, row_q;
  logic [AW-1:0]           addr_q;
  logic signed [15:0]      res_fx_q, res_fy_q;
  logic                    res_oor_q;

  // Sweep pipeline (clear, fade, reset zeroing)
  logic [AW-1:0]           swp_q;
  logic                    fd_iss_q;
  logic                    p1_v_q, p2_v_q;
  logic [AW-1:0]           p1_a_q, p2_a_q;
  logic signed [15:0]      p2_x_q, p2_y_q;

  // RAM
  logic [31:0]             fld_mem [DEPTH];
  logic [31:0]             rdata_q;
  logic                    mem_re, mem_we;
  logic [AW-1:0]           mem_raddr, mem_waddr;
  logic [31:0]             mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) fld_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= fld_mem[mem_raddr];
  end

  // Cell arithmetic on the read word
  logic signed [15:0] cur_x, cur_y;
  logic signed [17:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic signed [32:0] smp_x, smp_y, fd_x, fd_y;

  assign cur_x = rdata_q[15:0];
  assign cur_y = rdata_q[31:16];
  // sign-extended cell plus twice the vector
  assign sum_x = {{2{cur_x[15]}}, cur_x} + {vec_x_q[15], vec_x_q, 1'b0};
  assign sum_y = {{2{cur_y[15]}}, cur_y} + {vec_y_q[15], vec_y_q, 1'b0};
  assign smp_x = 33'(cur_x) * 33'(vfg_pkg::TENTH_Q16);
  assign smp_y = 33'(cur_y) * 33'(vfg_pkg::TENTH_Q16);
  assign fd_x  = 33'(cur_x) * $signed({17'd0, fade_q});
  assign fd_y  = 33'(cur_y) * $signed({17'd0, fade_q});

  always_comb begin
    if (sum_x[17:15] == 3'b000 || sum_x[17:15] == 3'b111) sat_x = sum_x[15:0];
    else sat_x = sum_x[17] ? 16'sh8000 : 16'sh7fff;
    if (sum_y[17:15] == 3'b000 || sum_y[17:15] == 3'b111) sat_y = sum_y[15:0];
    else sat_y = sum_y[17] ? 16'sh8000 : 16'sh7fff;
  end

  // RAM port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    mem_we    = 1'b0;
    mem_waddr = swp_q;
    mem_wdata = '0;
    case (state_q)
      ST_INIT, ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_CALC: begin
        mem_we    = is_add_q;
        mem_waddr = addr_q;
        mem_wdata = {sat_y, sat_x};
      end
      ST_FADE: begin
        mem_re    = fd_iss_q;
        mem_raddr = swp_q;
        mem_we    = p2_v_q;
        mem_waddr = p2_a_q;
        mem_wdata = {p2_y_q, p2_x_q};
      end
      default: ;
    endcase
  end

  // Next state
  assign result_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (swp_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (is_cell_op) state_d = oor ? ST_DONE : ST_DIV;
          else if (func_i == vfg_pkg::FUNC_FADE) state_d = ST_FADE;
          else state_d = ST_CLR;
        end
      end
      ST_DIV:  if (!busy_x && !busy_y) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_FADE: if (!fd_iss_q && !p1_v_q && !p2_v_q) state_d = ST_DONE;
      ST_CLR:  if (swp_q == LAST_ADDR) state_d = ST_DONE;
      ST_DONE: if (result_free) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      swp_q       <= '0;
      fd_iss_q    <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;

      // sweep address
      if (state_q == ST_INIT || state_q == ST_CLR ||
          (state_q == ST_FADE && fd_iss_q)) begin
        swp_q <= (swp_q == LAST_ADDR) ? '0 : swp_q + 1'b1;
      end

      // fade issue and pipe valids
      if (in_acc && func_i == vfg_pkg::FUNC_FADE) fd_iss_q <= 1'b1;
      else if (state_q == ST_FADE && swp_q == LAST_ADDR) fd_iss_q <= 1'b0;
      p1_v_q <= (state_q == ST_FADE) && fd_iss_q;
      p2_v_q <= p1_v_q;

      // output register
      if (state_q == ST_DONE && result_free) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_add_q  <= (func_i == vfg_pkg::FUNC_ADD);
      vec_x_q   <= vec_x_i;
      vec_y_q   <= vec_y_i;
      fade_q    <= fade_factor_i;
      cols_q    <= cols_eff;
      rows_q    <= rows_eff;
      res_fx_q  <= '0;
      res_fy_q  <= '0;
      res_oor_q <= is_cell_op && oor;
    end

    // clamp to the last cell in use
    if (state_q == ST_DIV) begin
      col_q <= (quot_x >= cols_q) ? cols_q - 1'b1 : quot_x;
      row_q <= (quot_y >= rows_q) ? rows_q - 1'b1 : quot_y;
    end

    // row-major word address
    if (state_q == ST_ADDR) begin
      addr_q <= AW'(32'(row_q) * 32'(cols_q) + 32'(col_q));
    end

    // sample result
    if (state_q == ST_CALC && !is_add_q) begin
      res_fx_q <= smp_x[31:16];
      res_fy_q <= smp_y[31:16];
    end

    // fade pipe
    p1_a_q <= swp_q;
    p2_a_q <= p1_a_q;
    p2_x_q <= fd_x[31:16];
    p2_y_q <= fd_y[31:16];

    if (state_q == ST_DONE && result_free) begin
      force_x_o      <= res_fx_q;
      force_y_o      <= res_fy_q;
      out_of_range_o <= res_oor_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vfg_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// The caller guarantees the quotient fits in QW bits.
module vfg_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 15,
  parameter int unsigned QW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic [QW-1:0]      quot_o
);

  localparam int unsigned SW   = DW + QW - 1;
  localparam int unsigned TW   = (NW > SW) ? NW : SW;
  localparam int unsigned CNTW = (QW > 1) ? $clog2(QW) : 1;

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   rem_q;
  logic [SW-1:0]   dsh_q;
  logic [QW-1:0]   quot_q;
  logic [TW-1:0]   rem_w, dsh_w, diff_w;
  logic            ge;

  assign rem_w  = TW'(rem_q);
  assign dsh_w  = TW'(dsh_q);
  assign ge     = rem_w >= dsh_w;
  assign diff_w = rem_w - dsh_w;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(QW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // datapath: trial subtract of the shifted divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= SW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= NW'(diff_w);
      dsh_q  <= dsh_q >> 1;
      quot_q <= (quot_q << 1) | QW'(ge);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ dv/tb_vector_field_grid_sample_and_splat_core.sv @@
`timescale 1ns / 1ps

module tb_vector_field_grid_sample_and_splat_core;

  localparam int MaxCols   = 64;
  localparam int MaxRows   = 64;
  localparam int CellCount = MaxCols * MaxRows;

  typedef struct packed {
    vfg_pkg::func_e     func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic [15:0]        fade;
  } field_op_t;

  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic               oor;
  } force_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // driven inputs
  logic                         cfg_valid = 1'b0;
  logic [vfg_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [vfg_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  field_op_t                    cur_op    = '0;
  logic                         out_stall = 1'b0;

  // block outputs
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [15:0] force_x_o;
  logic signed [15:0] force_y_o;
  logic               out_of_range_o;

  // shadow of the grid and its registers
  logic [31:0]  grid_cells [CellCount];
  logic [6:0]   m_cols;
  logic [6:0]   m_rows;
  logic [10:0]  m_ext_x;
  logic [10:0]  m_ext_y;

  field_op_t op_queue[$];
  force_t    force_expected[$];
  int        ops_open     = 0;
  int        mismatches   = 0;
  int        cycle_count  = 0;
  int        cycle_budget = 3 * CellCount + 2000;
  bit        idle_on      = 1'b1;
  int        in_gap       = 0;
  int        stall_left   = 0;

  vector_field_grid_sample_and_splat_core #(
    .MAX_COLUMNS(MaxCols),
    .MAX_ROWS   (MaxRows)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .func_i        (cur_op.func),
    .pos_x_i       (cur_op.pos_x),
    .pos_y_i       (cur_op.pos_y),
    .vec_x_i       (cur_op.vec_x),
    .vec_y_i       (cur_op.vec_y),
    .fade_factor_i (cur_op.fade),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .force_x_o     (force_x_o),
    .force_y_o     (force_y_o),
    .out_of_range_o(out_of_range_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // floor(v * m / 2^16)
  function automatic int scale_q16(int v, int m);
    longint p;
    p = longint'(v) * longint'(m);
    return int'(p >>> 16);
  endfunction

  function automatic int eff_size(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // cell index along one axis, -1 when outside 0..extent*16
  function automatic int axis_cell(int pos, int cells, int extent);
    int span;
    int c;
    span = extent * 16;
    if (pos < 0 || pos > span) return -1;
    c = (pos * cells) / span;
    return (c > cells - 1) ? cells - 1 : c;
  endfunction

  function automatic force_t field_step(field_op_t op);
    force_t r;
    int     cols, rows, cx, cy, addr, vx, vy, dvx, dvy, f, i;
    r = '0;
    case (op.func)
      vfg_pkg::FUNC_SAMPLE, vfg_pkg::FUNC_ADD: begin
        cols = eff_size(m_cols, MaxCols);
        rows = eff_size(m_rows, MaxRows);
        cx = axis_cell($signed(op.pos_x), cols, (m_ext_x == 0) ? 1 : m_ext_x);
        cy = axis_cell($signed(op.pos_y), rows, (m_ext_y == 0) ? 1 : m_ext_y);
        if (cx < 0 || cy < 0) begin
          r.oor = 1'b1;
        end else begin
          addr = (cy * cols + cx) % CellCount;
          vx = $signed(grid_cells[addr][15:0]);
          vy = $signed(grid_cells[addr][31:16]);
          if (op.func == vfg_pkg::FUNC_SAMPLE) begin
            r.fx = 16'(scale_q16(vx, int'(vfg_pkg::TENTH_Q16)));
            r.fy = 16'(scale_q16(vy, int'(vfg_pkg::TENTH_Q16)));
          end else begin
            dvx = $signed(op.vec_x);
            dvy = $signed(op.vec_y);
            vx = sat16(vx + 2 * dvx);
            vy = sat16(vy + 2 * dvy);
            grid_cells[addr] = {16'(vy), 16'(vx)};
          end
        end
      end
      vfg_pkg::FUNC_FADE: begin
        f = op.fade;
        for (i = 0; i < CellCount; i++) begin
          vx = $signed(grid_cells[i][15:0]);
          vy = $signed(grid_cells[i][31:16]);
          grid_cells[i] = {16'(scale_q16(vy, f)), 16'(scale_q16(vx, f))};
        end
      end
      default: begin
        for (i = 0; i < CellCount; i++) grid_cells[i] = '0;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one item per handshake, random gap (when idle_on is set) after each
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur_op   <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall_o)
        force_expected.insert(force_expected.size(), field_step(cur_op));
      if (!in_valid || !in_stall_o) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (op_queue.size() != 0) begin
          cur_op   <= op_queue.pop_front();
          in_valid <= 1'b1;
          in_gap   <= idle_on ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random stall per item when idle_on is set, compare against oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin : take_result
      int     nxt;
      force_t want;
      nxt = stall_left;
      if (out_valid_o && !out_stall) begin
        if (force_expected.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = force_expected.pop_front();
          ops_open--;
          if (force_x_o !== want.fx)
            report_mismatch($sformatf("force_x got %h want %h", force_x_o, want.fx));
          if (force_y_o !== want.fy)
            report_mismatch($sformatf("force_y got %h want %h", force_y_o, want.fy));
          if (out_of_range_o !== want.oor)
            report_mismatch($sformatf("out_of_range got %b want %b",
                                      out_of_range_o, want.oor));
        end
        nxt = idle_on ? $urandom_range(0, 5) : 0;
      end else if (out_valid_o && stall_left != 0) begin
        nxt = stall_left - 1;
      end
      stall_left <= nxt;
      out_stall  <= (nxt != 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic field_op_t mk(vfg_pkg::func_e f, int px, int py, int vx, int vy,
                                   int ff);
    field_op_t r;
    r.func  = f;
    r.pos_x = 16'(px);
    r.pos_y = 16'(py);
    r.vec_x = 16'(vx);
    r.vec_y = 16'(vy);
    r.fade  = 16'(ff);
    return r;
  endfunction

  task automatic queue_op(input field_op_t op);
    op_queue.insert(op_queue.size(), op);
    ops_open++;
    cycle_budget += (op.func == vfg_pkg::FUNC_FADE || op.func == vfg_pkg::FUNC_CLEAR)
                    ? 12500 : 200;
  endtask

  task automatic wait_drained();
    while (ops_open != 0) @(posedge clk_i);
  endtask

  // mostly hot cells, some spread, some on the bounds, some outside
  function automatic logic [15:0] pick_pos(int span, logic [15:0] hot);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return hot;
    if (roll < 85) return 16'($urandom_range(0, span));
    if (roll < 88) return 16'(span);
    if (roll < 90) return 16'd0;
    if (roll < 95) return 16'(span + 1 + $urandom_range(0, 32767 - span));
    return 16'($urandom_range(32768, 65535));
  endfunction

  function automatic logic [15:0] pick_vec();
    if ($urandom_range(0, 1) != 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  // writes a junk index, then all four registers, valid held across writes
  task automatic program_grid(input logic [6:0] cols, input logic [6:0] rows,
                              input logic [10:0] ex, input logic [10:0] ey);
    logic [vfg_pkg::CfgIdxW-1:0]  idx [5];
    logic [vfg_pkg::CfgDataW-1:0] dat [5];
    int                           k;
    idx[0] = 3'(4 + $urandom_range(0, 3));
    dat[0] = 11'($urandom);
    idx[1] = vfg_pkg::CFG_GRID_COLUMNS;
    dat[1] = {4'($urandom), cols};
    idx[2] = vfg_pkg::CFG_GRID_ROWS;
    dat[2] = {4'($urandom), rows};
    idx[3] = vfg_pkg::CFG_EXTENT_X;
    dat[3] = ex;
    idx[4] = vfg_pkg::CFG_EXTENT_Y;
    dat[4] = ey;
    cfg_valid <= 1'b1;
    for (k = 0; k < 5; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      cycle_budget += 50;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[k])
        vfg_pkg::CFG_GRID_COLUMNS: m_cols  = dat[k][6:0];
        vfg_pkg::CFG_GRID_ROWS:    m_rows  = dat[k][6:0];
        vfg_pkg::CFG_EXTENT_X:     m_ext_x = dat[k];
        vfg_pkg::CFG_EXTENT_Y:     m_ext_y = dat[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    field_op_t   op;
    int          ph, n, k, roll, span_x, span_y, i;
    logic [15:0] hot_x [6];
    logic [15:0] hot_y [6];

    for (i = 0; i < CellCount; i++) grid_cells[i] = '0;
    m_cols  = vfg_pkg::GRID_COLUMNS_RST;
    m_rows  = vfg_pkg::GRID_ROWS_RST;
    m_ext_x = vfg_pkg::EXTENT_X_RST;
    m_ext_y = vfg_pkg::EXTENT_Y_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset layout (64x64 cells, spans 16384 x 12288)
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_ADD, 0, 0, 32767, -32768, 0));       // saturate both ways
    queue_op(mk(vfg_pkg::FUNC_ADD, 0, 0, 1, -1, 65535));           // stays saturated
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, -32768, 32767, 65535)); // floor of negative tenth
    queue_op(mk(vfg_pkg::FUNC_ADD, 16384, 12288, 291, -69, 0));    // exactly at extent
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 16383, 12287, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 16385, 0, 0, 0, 0));         // just past extent
    queue_op(mk(vfg_pkg::FUNC_ADD, -1, 100, 1000, 1000, 0));       // outside: store untouched
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 100, -32768, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 32767, 32767, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_ADD, 256, 192, -32767, 4660, 0));
    queue_op(mk(vfg_pkg::FUNC_FADE, 0, 0, 0, 0, 65535));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 256, 192, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_FADE, 5, 5, 5, 5, 32768));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 16384, 12288, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_FADE, 0, 0, 0, 0, 0));               // wipes everything
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_ADD, 0, 0, 256, 512, 0));
    queue_op(mk(vfg_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));
    queue_op(mk(vfg_pkg::FUNC_ADD, 255, 191, -300, 300, 0));
    queue_op(mk(vfg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0));

    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1:       program_grid(7'd1, 7'd1, 11'd1, 11'd1);
          2:       program_grid(7'd64, 7'd64, 11'd2047, 11'd2047);
          3:       program_grid(7'd0, 7'd0, 11'd0, 11'd0);      // zero sizes act as one
          4:       program_grid(7'd127, 7'd100, 11'd5, 11'd3);  // oversize saturates
          default: program_grid(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                11'($urandom_range(1, 2047)), 11'($urandom_range(1, 2047)));
        endcase
      end
      idle_on = (ph != 2 && ph != 5);
      span_x  = ((m_ext_x == 0) ? 1 : int'(m_ext_x)) * 16;
      span_y  = ((m_ext_y == 0) ? 1 : int'(m_ext_y)) * 16;
      for (k = 0; k < 6; k++) begin
        hot_x[k] = 16'($urandom_range(0, span_x));
        hot_y[k] = 16'($urandom_range(0, span_y));
      end

      // random items, mostly hitting a few hot cells so adds and samples meet
      for (n = 0; n < 190; n++) begin
        k    = $urandom_range(0, 5);
        roll = $urandom_range(0, 999);
        if (roll < 470)      op.func = vfg_pkg::FUNC_SAMPLE;
        else if (roll < 970) op.func = vfg_pkg::FUNC_ADD;
        else if (roll < 990) op.func = vfg_pkg::FUNC_FADE;
        else                 op.func = vfg_pkg::FUNC_CLEAR;
        op.pos_x = pick_pos(span_x, hot_x[k]);
        op.pos_y = pick_pos(span_y, hot_y[k]);
        op.vec_x = pick_vec();
        op.vec_y = pick_vec();
        op.fade  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(49152, 65535))
                                              : 16'($urandom);
        queue_op(op);
      end
    end

    wait_drained();
    cycle_budget += 200;
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ vector_field_grid_sample_and_splat_core.f @@
hw/rtl/vfg_pkg.sv
hw/rtl/vfg_div.sv
hw/rtl/vector_field_grid_sample_and_splat_core.sv
dv/tb_vector_field_grid_sample_and_splat_core.sv
